/* design/paf_pkg.sv */
// Shared types, constants and defaults of the pitot airspeed block.
package paf_pkg;

   localparam int GainWidth = 16;
   localparam logic [GainWidth-1:0] GainReset = 16'd256;
   localparam int QueueDepthDefault = 4;

   localparam int DpWidth = 24;
   localparam int TempWidth = 16;
   localparam int PresWidth = 17;
   localparam int RawWidth = 16;
   localparam int SpeedWidth = 16;

   localparam int NumWidth = 55;
   localparam int DenWidth = 31;
   localparam int QuotWidth = 32;
   localparam int RemWidth = 18;

   localparam logic signed [16:0] KelvinOffset = 17'sd27315;
   localparam logic [13:0] BaroDenScale = 14'd10000;
   localparam logic [15:0] BaroNumScale = 16'd57410;
   localparam logic [6:0] DefaultNumScale = 7'd80;
   localparam logic [DenWidth-1:0] DefaultDen = 31'd49;
   localparam logic [SpeedWidth-1:0] SpeedMax = 16'hFFFF;

   typedef struct packed {
      logic ok;
      logic signed [DpWidth-1:0] dp;
      logic signed [TempWidth-1:0] temp;
      logic pos;
   } meta_type;

   typedef struct packed {
      meta_type meta;
      logic [NumWidth-1:0] num;
      logic [DenWidth-1:0] den;
   } item_type;

endpackage

/* design/paf_front.sv */
// Front part: gain scaling, density selection and numerator/denominator products.
module paf_front (
   input  logic clock,
   input  logic reset,
   input  logic push,
   output logic full,
   input  logic req_read_ok,
   input  logic signed [paf_pkg::RawWidth-1:0] req_raw_diff,
   input  logic [paf_pkg::PresWidth-1:0] req_baro_pressure,
   input  logic signed [paf_pkg::TempWidth-1:0] req_baro_temp,
   input  logic csr_wr_en,
   input  logic [paf_pkg::GainWidth-1:0] csr_wr_data,
   input  logic q_full,
   output logic q_push,
   output paf_pkg::item_type q_item
);
   import paf_pkg::*;

   logic [GainWidth-1:0] gain_ff;
   logic f1_valid_ff, f2_valid_ff;
   logic f1_ok_ff;
   logic signed [31:0] f1_prod_ff;
   logic signed [TempWidth-1:0] f1_temp_ff;
   logic [PresWidth-1:0] f1_pres_ff;
   meta_type f2_meta_ff, f2_meta_in;
   logic f2_baro_ff, f2_baro_in;
   logic [38:0] f2_a_ff, f2_a_in;
   logic [DenWidth-1:0] f2_den_ff, f2_den_in;
   logic signed [31:0] f1_prod_in;
   logic signed [DpWidth-1:0] dp;
   logic signed [16:0] tc;
   logic adv;
   logic [NumWidth-1:0] baro_num;

   assign adv = !q_full;
   assign full = q_full;

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff <= GainReset;
      end else if (csr_wr_en) begin
         gain_ff <= csr_wr_data;
      end
   end

   assign f1_prod_in = 32'(req_raw_diff) * 32'($signed({1'b0, gain_ff}));

   always_comb begin
      dp = f1_prod_ff[31:8];
      tc = 17'(f1_temp_ff) + KelvinOffset;
      f2_meta_in.ok = f1_ok_ff;
      f2_meta_in.dp = f1_ok_ff ? dp : '0;
      f2_meta_in.temp = f1_ok_ff ? f1_temp_ff : '0;
      f2_meta_in.pos = f1_ok_ff && (dp > 0);
      f2_baro_in = (f1_pres_ff != '0) && (tc > 0);
      f2_a_in = 39'(dp[22:0]) * 39'(tc[15:0]);
      f2_den_in = 31'(f1_pres_ff) * 31'(BaroDenScale);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f1_valid_ff <= 1'b0;
         f2_valid_ff <= 1'b0;
      end else if (adv) begin
         f1_valid_ff <= push;
         f2_valid_ff <= f1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         f1_ok_ff <= req_read_ok;
         f1_prod_ff <= f1_prod_in;
         f1_temp_ff <= req_baro_temp;
         f1_pres_ff <= req_baro_pressure;
         f2_meta_ff <= f2_meta_in;
         f2_baro_ff <= f2_baro_in;
         f2_a_ff <= f2_a_in;
         f2_den_ff <= f2_den_in;
      end
   end

   always_comb begin
      baro_num = NumWidth'(f2_a_ff) * NumWidth'(BaroNumScale);
      q_push = f2_valid_ff && adv;
      q_item.meta = f2_meta_ff;
      q_item.num = f2_baro_ff ? baro_num
                              : NumWidth'(f2_meta_ff.dp[22:0]) * NumWidth'(DefaultNumScale);
      q_item.den = f2_baro_ff ? f2_den_ff : DefaultDen;
   end

endmodule

/* design/paf_queue.sv */
// Small register queue between the front and back parts.
module paf_queue #(
   parameter int Depth = paf_pkg::QueueDepthDefault
) (
   input  logic clock,
   input  logic reset,
   input  logic wr_en,
   input  paf_pkg::item_type wr_item,
   input  logic rd_en,
   output paf_pkg::item_type rd_item,
   output logic q_full,
   output logic q_empty
);
   import paf_pkg::*;

   localparam int PtrWidth = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CntWidth = $clog2(Depth + 1);

   item_type mem_ff [Depth];
   logic [PtrWidth-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CntWidth-1:0] count_ff;
   logic do_wr, do_rd;

   assign q_full = (count_ff == CntWidth'(Depth));
   assign q_empty = (count_ff == '0);
   assign do_wr = wr_en && !q_full;
   assign do_rd = rd_en && !q_empty;
   assign rd_item = mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         if (do_wr) begin
            wr_ptr_ff <= (wr_ptr_ff == PtrWidth'(Depth - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (do_rd) begin
            rd_ptr_ff <= (rd_ptr_ff == PtrWidth'(Depth - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         count_ff <= count_ff + CntWidth'(do_wr) - CntWidth'(do_rd);
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         mem_ff[wr_ptr_ff] <= wr_item;
      end
   end

endmodule

/* design/paf_back.sv */
// Back part: pipelined divider, pipelined square root and result register.
module paf_back (
   input  logic clock,
   input  logic reset,
   input  logic q_empty,
   input  paf_pkg::item_type q_item,
   output logic q_pop,
   output logic empty,
   input  logic pop,
   output logic rsp_valid_res,
   output logic signed [paf_pkg::DpWidth-1:0] rsp_diff_pressure,
   output logic [paf_pkg::SpeedWidth-1:0] rsp_indicated_speed,
   output logic [paf_pkg::SpeedWidth-1:0] rsp_true_speed,
   output logic signed [paf_pkg::TempWidth-1:0] rsp_temp_out
);
   import paf_pkg::*;

   localparam int DivSteps = QuotWidth;
   localparam int SqrtSteps = SpeedWidth;

   typedef struct packed {
      meta_type meta;
      logic sat;
      logic [DenWidth-1:0] den;
      logic [DenWidth-1:0] r;
      logic [QuotWidth-1:0] d;
      logic [QuotWidth-1:0] q;
   } div_type;

   typedef struct packed {
      meta_type meta;
      logic sat;
      logic [QuotWidth-1:0] x;
      logic [RemWidth-1:0] rem;
      logic [SpeedWidth-1:0] root;
   } sq_type;

   function automatic div_type div_step(div_type s);
      logic [DenWidth:0] r2;
      logic ge;
      div_type o;
      o = s;
      r2 = {s.r, s.d[QuotWidth-1]};
      ge = r2 >= {1'b0, s.den};
      o.r = ge ? DenWidth'(r2 - {1'b0, s.den}) : r2[DenWidth-1:0];
      o.d = {s.d[QuotWidth-2:0], 1'b0};
      o.q = {s.q[QuotWidth-2:0], ge};
      return o;
   endfunction

   function automatic sq_type sq_step(sq_type s);
      logic [RemWidth+1:0] rem2;
      logic [RemWidth+1:0] t;
      logic ge;
      sq_type o;
      o = s;
      rem2 = {s.rem, s.x[QuotWidth-1:QuotWidth-2]};
      t = (RemWidth + 2)'({s.root, 2'b01});
      ge = rem2 >= t;
      o.rem = ge ? RemWidth'(rem2 - t) : rem2[RemWidth-1:0];
      o.root = {s.root[SpeedWidth-2:0], ge};
      o.x = {s.x[QuotWidth-3:0], 2'b00};
      return o;
   endfunction

   div_type div_ff [DivSteps+1];
   div_type div_in [DivSteps+1];
   logic [DivSteps:0] dv_ff;
   sq_type sq_ff [SqrtSteps];
   sq_type sq_in [SqrtSteps];
   sq_type sq_init;
   logic [SqrtSteps-1:0] sv_ff;
   logic adv;
   logic out_valid_ff;
   meta_type out_meta_ff;
   logic [SpeedWidth-1:0] out_speed_ff, out_speed_in;

   assign adv = !out_valid_ff || pop;
   assign q_pop = adv && !q_empty;
   assign empty = !out_valid_ff;

   always_comb begin
      div_in[0].meta = q_item.meta;
      div_in[0].sat = q_item.num[NumWidth-1:16] >= 39'(q_item.den);
      div_in[0].den = q_item.den;
      div_in[0].r = q_item.num[DenWidth+15:16];
      div_in[0].d = {q_item.num[15:0], 16'h0000};
      div_in[0].q = '0;
      for (int k = 0; k < DivSteps; k++) begin
         div_in[k+1] = div_step(div_ff[k]);
      end
      sq_init.meta = div_ff[DivSteps].meta;
      sq_init.sat = div_ff[DivSteps].sat;
      sq_init.x = div_ff[DivSteps].q;
      sq_init.rem = '0;
      sq_init.root = '0;
      sq_in[0] = sq_step(sq_init);
      for (int k = 1; k < SqrtSteps; k++) begin
         sq_in[k] = sq_step(sq_ff[k-1]);
      end
      if (!sq_ff[SqrtSteps-1].meta.pos) begin
         out_speed_in = '0;
      end else if (sq_ff[SqrtSteps-1].sat) begin
         out_speed_in = SpeedMax;
      end else begin
         out_speed_in = sq_ff[SqrtSteps-1].root;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dv_ff <= '0;
         sv_ff <= '0;
         out_valid_ff <= 1'b0;
      end else if (adv) begin
         dv_ff <= {dv_ff[DivSteps-1:0], !q_empty};
         sv_ff <= {sv_ff[SqrtSteps-2:0], dv_ff[DivSteps]};
         out_valid_ff <= sv_ff[SqrtSteps-1];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int k = 0; k <= DivSteps; k++) begin
            div_ff[k] <= div_in[k];
         end
         for (int k = 0; k < SqrtSteps; k++) begin
            sq_ff[k] <= sq_in[k];
         end
         out_meta_ff <= sq_ff[SqrtSteps-1].meta;
         out_speed_ff <= out_speed_in;
      end
   end

   assign rsp_valid_res = out_meta_ff.ok;
   assign rsp_diff_pressure = out_meta_ff.dp;
   assign rsp_indicated_speed = out_speed_ff;
   assign rsp_true_speed = out_speed_ff;
   assign rsp_temp_out = out_meta_ff.temp;

endmodule

/* design/pitot_airspeed_from_pressure_top.sv */
// Top level of the pitot airspeed block.
//
// Samples are written like a queue: a beat is taken on each clock edge with
// push high and full low. Results are read like a queue: while empty is low
// the oldest result is on the rsp_ ports and pop takes it.
// The csr_ port writes the Q8.8 pressure gain; write it only while idle.
// One beat is accepted per cycle while full is low. Each accepted sample
// passes through two front stages, the queue, 33 divider stages,
// 16 square-root stages and the result register. The divider retires
// one bit per stage after its first; the square root one bit per stage.
// When the reader stalls, the back pipeline holds; the queue absorbs the
// front stages, and full rises once the queue fills.
// Reset clears the pipelines and the queue and sets the gain to 1.0.
module pitot_airspeed_from_pressure_top #(
   parameter int QueueDepth = paf_pkg::QueueDepthDefault
) (
   input  logic clock,
   input  logic reset,
   input  logic push,
   output logic full,
   input  logic req_read_ok,
   input  logic signed [paf_pkg::RawWidth-1:0] req_raw_diff,
   input  logic [paf_pkg::PresWidth-1:0] req_baro_pressure,
   input  logic signed [paf_pkg::TempWidth-1:0] req_baro_temp,
   output logic empty,
   input  logic pop,
   output logic rsp_valid_res,
   output logic signed [paf_pkg::DpWidth-1:0] rsp_diff_pressure,
   output logic [paf_pkg::SpeedWidth-1:0] rsp_indicated_speed,
   output logic [paf_pkg::SpeedWidth-1:0] rsp_true_speed,
   output logic signed [paf_pkg::TempWidth-1:0] rsp_temp_out,
   input  logic csr_wr_en,
   input  logic [paf_pkg::GainWidth-1:0] csr_wr_data
);
   import paf_pkg::*;

   logic q_full, q_empty, q_push, q_pop;
   item_type q_wr_item, q_rd_item;

   paf_front u_front (
      .clock(clock), .reset(reset), .push(push), .full(full),
      .req_read_ok(req_read_ok), .req_raw_diff(req_raw_diff),
      .req_baro_pressure(req_baro_pressure), .req_baro_temp(req_baro_temp),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data),
      .q_full(q_full), .q_push(q_push), .q_item(q_wr_item)
   );

   paf_queue #(.Depth(QueueDepth)) u_queue (
      .clock(clock), .reset(reset), .wr_en(q_push), .wr_item(q_wr_item),
      .rd_en(q_pop), .rd_item(q_rd_item), .q_full(q_full), .q_empty(q_empty)
   );

   paf_back u_back (
      .clock(clock), .reset(reset), .q_empty(q_empty), .q_item(q_rd_item),
      .q_pop(q_pop), .empty(empty), .pop(pop),
      .rsp_valid_res(rsp_valid_res), .rsp_diff_pressure(rsp_diff_pressure),
      .rsp_indicated_speed(rsp_indicated_speed), .rsp_true_speed(rsp_true_speed),
      .rsp_temp_out(rsp_temp_out)
   );

endmodule

/* design/paf_checker.sv */
// Port-level checker of the pitot airspeed block and its bind.
module paf_checker (
   input logic clock,
   input logic reset,
   input logic empty,
   input logic pop,
   input logic rsp_valid_res,
   input logic signed [paf_pkg::DpWidth-1:0] rsp_diff_pressure,
   input logic [paf_pkg::SpeedWidth-1:0] rsp_indicated_speed,
   input logic [paf_pkg::SpeedWidth-1:0] rsp_true_speed,
   input logic signed [paf_pkg::TempWidth-1:0] rsp_temp_out
);
   import paf_pkg::*;

   a_empty_after_reset: assert property (@(posedge clock) reset |=> empty)
      else $error("result queue not empty after reset");

   a_speeds_equal: assert property (@(posedge clock) disable iff (reset)
      !empty |-> rsp_true_speed == rsp_indicated_speed)
      else $error("true and indicated speed differ");

   a_failed_read_zero: assert property (@(posedge clock) disable iff (reset)
      (!empty && !rsp_valid_res) |-> (rsp_diff_pressure == '0
         && rsp_indicated_speed == '0 && rsp_temp_out == '0))
      else $error("failed read gives nonzero fields");

   a_no_speed_without_dp: assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_diff_pressure <= 0) |-> rsp_indicated_speed == '0)
      else $error("speed without positive differential pressure");

   a_hold_when_stalled: assert property (@(posedge clock) disable iff (reset)
      (!empty && !pop) |=> (!empty && $stable(rsp_diff_pressure)
         && $stable(rsp_indicated_speed)))
      else $error("stalled result changed");

endmodule

bind pitot_airspeed_from_pressure_top paf_checker u_paf_checker (
   .clock(clock), .reset(reset), .empty(empty), .pop(pop),
   .rsp_valid_res(rsp_valid_res), .rsp_diff_pressure(rsp_diff_pressure),
   .rsp_indicated_speed(rsp_indicated_speed), .rsp_true_speed(rsp_true_speed),
   .rsp_temp_out(rsp_temp_out)
);

/* sim/tb_pitot_airspeed_from_pressure_top.sv */
// Testbench for the pitot airspeed block: random and directed samples checked against a predictor.
`timescale 1ns / 1ps

module tb_pitot_airspeed_from_pressure_top;
   import paf_pkg::*;

   typedef struct {
      logic read_ok;
      logic signed [RawWidth-1:0] raw_diff;
      logic [PresWidth-1:0] baro_pressure;
      logic signed [TempWidth-1:0] baro_temp;
   } sample_type;

   typedef struct {
      logic valid_res;
      logic signed [DpWidth-1:0] diff_pressure;
      logic [SpeedWidth-1:0] indicated_speed;
      logic [SpeedWidth-1:0] true_speed;
      logic signed [TempWidth-1:0] temp_out;
   } airspeed_type;

   localparam int SettleCycles = 80;
   localparam int WatchdogLimit = 4000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic push = 1'b0;
   logic full;
   logic req_read_ok = 1'b0;
   logic signed [RawWidth-1:0] req_raw_diff = '0;
   logic [PresWidth-1:0] req_baro_pressure = '0;
   logic signed [TempWidth-1:0] req_baro_temp = '0;
   logic empty;
   logic pop = 1'b0;
   logic rsp_valid_res;
   logic signed [DpWidth-1:0] rsp_diff_pressure;
   logic [SpeedWidth-1:0] rsp_indicated_speed;
   logic [SpeedWidth-1:0] rsp_true_speed;
   logic signed [TempWidth-1:0] rsp_temp_out;
   logic csr_wr_en = 1'b0;
   logic [GainWidth-1:0] csr_wr_data = '0;

   sample_type pending_samples[$];
   airspeed_type expected_airspeeds[$];
   logic [GainWidth-1:0] model_gain = GainReset;
   int errors = 0;
   int idle_cycles = 0;
   int burst_left = 0;
   int gap_left = 0;
   int stall_phase = 0;
   bit hold_driver = 1'b1;

   pitot_airspeed_from_pressure_top dut (
      .clock(clock), .reset(reset), .push(push), .full(full),
      .req_read_ok(req_read_ok), .req_raw_diff(req_raw_diff),
      .req_baro_pressure(req_baro_pressure), .req_baro_temp(req_baro_temp),
      .empty(empty), .pop(pop), .rsp_valid_res(rsp_valid_res),
      .rsp_diff_pressure(rsp_diff_pressure), .rsp_indicated_speed(rsp_indicated_speed),
      .rsp_true_speed(rsp_true_speed), .rsp_temp_out(rsp_temp_out),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic longint unsigned int_sqrt(longint unsigned x);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > x) b >>= 2;
      while (b != 0) begin
         if (x >= r + b) begin
            x -= r + b;
            r = (r >> 1) + b;
         end else begin
            r >>= 1;
         end
         b >>= 2;
      end
      return r;
   endfunction

   function automatic airspeed_type compute_airspeed(sample_type s,
                                                     logic [GainWidth-1:0] gain);
      airspeed_type a;
      longint prod, dp, tc;
      longint unsigned num, den, spd;
      a = '{default: '0};
      if (!s.read_ok) return a;
      prod = longint'(s.raw_diff) * longint'(gain);
      dp = prod >>> 8;
      if (dp > 8388607) dp = 8388607;
      if (dp < -8388608) dp = -8388608;
      tc = longint'(s.baro_temp) + 27315;
      spd = 0;
      if (dp > 0) begin
         if (s.baro_pressure != 0 && tc > 0) begin
            num = 2 * dp * 28705 * tc;
            den = 10000 * longint'(s.baro_pressure);
         end else begin
            num = 80 * dp;
            den = 49;
         end
         spd = (num >= (den << 16)) ? 65535 : int_sqrt((num << 16) / den);
      end
      a.valid_res = 1'b1;
      a.diff_pressure = dp[DpWidth-1:0];
      a.indicated_speed = spd[15:0];
      a.true_speed = spd[15:0];
      a.temp_out = s.baro_temp;
      return a;
   endfunction

   task automatic add_sample(bit ok, int raw, int pres, int temp);
      sample_type s;
      s.read_ok = ok;
      s.raw_diff = raw[15:0];
      s.baro_pressure = pres[16:0];
      s.baro_temp = temp[15:0];
      pending_samples.push_back(s);
   endtask

   task automatic add_random(int n);
      repeat (n) begin
         case ($urandom_range(0, 3))
            0: add_sample($urandom_range(0, 1), $urandom, $urandom, $urandom);
            1: add_sample($urandom_range(0, 7) != 0, $urandom_range(0, 2000),
                  $urandom_range(80000, 110000), $urandom_range(0, 5000) - 2000);
            2: add_sample(1, $urandom_range(0, 300), $urandom_range(0, 3) == 0 ? 0 :
                  $urandom_range(1, 131071), $urandom_range(0, 65535));
            default: add_sample(1, $urandom, $urandom_range(1, 131071), $urandom);
         endcase
      end
   endtask

   // Lets the queue drain fully, then waits out the pipeline before a gain write.
   task automatic run_and_drain(logic [GainWidth-1:0] gain);
      hold_driver = 1'b0;
      wait (pending_samples.size() == 0 && expected_airspeeds.size() == 0);
      hold_driver = 1'b1;
      repeat (SettleCycles) @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= gain;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      model_gain = gain;
   endtask

   always @(posedge clock) begin
      if (!reset && push && !full) begin
         expected_airspeeds.push_back(compute_airspeed(pending_samples[0], model_gain));
         void'(pending_samples.pop_front());
      end
      if (push && full) begin
         push <= 1'b1;
      end else if (reset || hold_driver || pending_samples.size() == 0) begin
         push <= 1'b0;
      end else begin
         if (burst_left == 0 && gap_left == 0) begin
            burst_left = $urandom_range(1, 30);
            gap_left = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 6);
         end
         if (burst_left > 0) begin
            push <= 1'b1;
            req_read_ok <= pending_samples[0].read_ok;
            req_raw_diff <= pending_samples[0].raw_diff;
            req_baro_pressure <= pending_samples[0].baro_pressure;
            req_baro_temp <= pending_samples[0].baro_temp;
            burst_left--;
         end else begin
            push <= 1'b0;
            gap_left--;
         end
      end
   end

   always @(posedge clock) begin
      airspeed_type e;
      if (!reset && pop && !empty) begin
         if (expected_airspeeds.size() == 0) begin
            $error("result beat with no expectation");
            errors++;
         end else begin
            e = expected_airspeeds.pop_front();
            if (rsp_valid_res !== e.valid_res) begin
               $error("valid_res exp %0d got %0d", e.valid_res, rsp_valid_res); errors++;
            end
            if (rsp_diff_pressure !== e.diff_pressure) begin
               $error("diff_pressure exp %0d got %0d", e.diff_pressure, rsp_diff_pressure);
               errors++;
            end
            if (rsp_indicated_speed !== e.indicated_speed) begin
               $error("indicated_speed exp %0d got %0d", e.indicated_speed,
                  rsp_indicated_speed);
               errors++;
            end
            if (rsp_true_speed !== e.true_speed) begin
               $error("true_speed exp %0d got %0d", e.true_speed, rsp_true_speed); errors++;
            end
            if (rsp_temp_out !== e.temp_out) begin
               $error("temp_out exp %0d got %0d", e.temp_out, rsp_temp_out); errors++;
            end
         end
      end
      stall_phase = (stall_phase + 1) % 97;
      pop <= !reset && (stall_phase < 40 || $urandom_range(0, 2) != 0);
   end

   always @(posedge clock) begin
      if (reset || hold_driver || (push && !full) || (pop && !empty)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WatchdogLimit) begin
         $display("tb_pitot_airspeed_from_pressure_top NOT OK");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      add_sample(0, 1234, 100000, 2000);
      add_sample(1, 32767, 101325, 1500);
      add_sample(1, -32768, 101325, 1500);
      add_sample(1, 0, 101325, 1500);
      add_sample(1, -1, 101325, 1500);
      add_sample(1, 1, 131071, 32767);
      add_sample(1, 500, 0, 1500);
      add_sample(1, 500, 100000, -27315);
      add_sample(1, 500, 100000, -32768);
      add_sample(1, 500, 100000, -27314);
      add_sample(1, 32767, 1, 32767);
      add_sample(1, 40, 101325, 0);
      add_sample(1, 32767, 0, -32768);
      add_sample(1, 12345, 65536, -1);
      add_random(150);
      run_and_drain(16'hFFFF);
      add_sample(1, 32767, 101325, 1500);
      add_sample(1, -32768, 101325, 1500);
      add_sample(1, 32767, 0, 0);
      add_random(150);
      run_and_drain(16'h0000);
      add_random(60);
      run_and_drain(16'd1);
      add_sample(1, -1, 100000, 0);
      add_sample(1, 255, 100000, 0);
      add_random(100);
      run_and_drain(16'd5000);
      add_random(150);
      hold_driver = 1'b0;
      wait (pending_samples.size() == 0 && expected_airspeeds.size() == 0);
      repeat (SettleCycles) @(posedge clock);
      if (errors == 0) $display("tb_pitot_airspeed_from_pressure_top OK");
      else $display("tb_pitot_airspeed_from_pressure_top NOT OK");
      $finish;
   end

endmodule
